FILE: hdl/brfcs_pkg.sv
// ----------------------------------------------------------------------------
// brfcs_pkg
// Shared constants, opcodes and cell control type for the byte queue with
// character search.
// ----------------------------------------------------------------------------
package brfcs_pkg;

  // Default queue depth (power of two)
  localparam int QUEUE_DEPTH = 64;

  // Longest run of results one pop may give
  localparam int MAX_RUN = 64;

  // Fixed field widths of the stream payloads
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int OP_W    = 2;

  // Packed payload widths (whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Opcodes carried on in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic              rotate;   // every cell takes its upper neighbor
    logic              push;     // the cell at the fill position loads byte_in
    logic [BYTE_W-1:0] byte_in;
  } cell_ctl_t;

endpackage

FILE: hdl/brfcs_cell.sv
// ----------------------------------------------------------------------------
// brfcs_cell
// One byte cell of the queue chain: loads a pushed byte when it sits at the
// fill position, or takes its neighbor's byte when the chain rotates.
// ----------------------------------------------------------------------------
module brfcs_cell #(
  parameter int DEPTH = brfcs_pkg::QUEUE_DEPTH,
  parameter int IDX   = 0
) (
  input  logic                           clk,
  input  brfcs_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(DEPTH+1)-1:0]     fill,
  input  logic [brfcs_pkg::BYTE_W-1:0]   nb_byte,
  output logic [brfcs_pkg::BYTE_W-1:0]   byte_q
);

  localparam int FW = $clog2(DEPTH + 1);

  logic [brfcs_pkg::BYTE_W-1:0] byte_r;
  logic [brfcs_pkg::BYTE_W-1:0] byte_nxt;
  logic                         sel;

  // Decode the write position
  assign sel = (fill == FW'(IDX));

  // Pick the next content: rotate wins, else a push to this slot
  always_comb begin
    byte_nxt = byte_r;
    if (ctl.rotate) begin
      byte_nxt = nb_byte;
    end else if (ctl.push && sel) begin
      byte_nxt = ctl.byte_in;
    end
  end

  // Hold the byte (no reset: content is defined by the fill count)
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

FILE: hdl/brfcs_chain.sv
// ----------------------------------------------------------------------------
// brfcs_chain
// Row of byte cells in queue order, oldest byte in cell 0. Rotation moves
// every byte one cell toward the head and wraps the head to the tail.
// ----------------------------------------------------------------------------
module brfcs_chain #(
  parameter int DEPTH = brfcs_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  brfcs_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(DEPTH+1)-1:0]     fill,
  output logic [brfcs_pkg::BYTE_W-1:0]   head_byte
);

  logic [brfcs_pkg::BYTE_W-1:0] cell_q [DEPTH];

  // Link each cell to its upper neighbor, the tail to the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    brfcs_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .fill    (fill),
      .nb_byte (cell_q[(i + 1) % DEPTH]),
      .byte_q  (cell_q[i])
    );
  end

  assign head_byte = cell_q[0];

endmodule

FILE: hdl/byte_ring_fifo_with_char_search.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_char_search
// Byte queue with push, multi-byte pop, oldest-first character search and
// clear, built as a chain of byte cells with a fill counter.
//
//  channel  ports                       payload (low bit up)
//  -------  --------------------------  -------------------------------------
//  input    in_tvalid/in_tready         tuser: opcode; tdata: data_byte,
//                                       request_count
//  output   out_tvalid/out_tready       tuser: out_valid; tlast: last_of_run;
//                                       tdata: out_byte, moved_count,
//                                       fill_level, is_empty, is_full
//
// Push and clear give their result in the cycle after the transfer. Pop first
// enters its pop state, then gives one byte per cycle while the output slot
// is free, one cell shift each. Peek rotates the chain once all the way round
// while the head cell is compared, so the queue ends up unchanged. One item is
// in work at a time. Reset clears the fill count and state; cell contents are
// not reset. A stalled output register holds its result and pauses pop and
// the final peek step.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_char_search #(
  parameter int QUEUE_DEPTH = brfcs_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tuser: opcode[1:0]
  // tdata: data_byte[7:0], request_count[14:8], zero[15]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [brfcs_pkg::OP_W-1:0]           in_tuser,
  input  logic [brfcs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: out_valid[0]
  // tdata: out_byte[7:0], moved_count[14:8], fill_level[21:15],
  //        is_empty[22], is_full[23]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  output logic [brfcs_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(QUEUE_DEPTH);
  localparam int CW = brfcs_pkg::COUNT_W;
  localparam int NW = (FW > CW) ? FW : CW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_PEEK = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [FW-1:0]               fill_r, fill_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]               total_r, total_nxt;
  logic [SW-1:0]               step_r, step_nxt;
  logic                        found_r, found_nxt;
  logic [FW-1:0]               dist_r, dist_nxt;
  logic [brfcs_pkg::BYTE_W-1:0] char_r, char_nxt;

  // Output register
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [brfcs_pkg::BYTE_W-1:0] ob_r;
  logic                         oflag_r;
  logic [CW-1:0]                omoved_r;
  logic                         olast_r;
  logic [CW-1:0]                ofill_r;
  logic                         oempty_r;
  logic                         ofull_r;

  // Result being produced this cycle
  logic                         emit;
  logic [brfcs_pkg::BYTE_W-1:0] res_byte;
  logic                         res_flag;
  logic [CW-1:0]                res_moved;
  logic                         res_last;

  brfcs_pkg::cell_ctl_t         ctl;
  logic [brfcs_pkg::BYTE_W-1:0] head_byte;

  brfcs_pkg::op_t               in_op;
  logic [brfcs_pkg::BYTE_W-1:0] in_data;
  logic [CW-1:0]                in_req;
  logic                         in_acc;
  logic                         load_ok;
  logic [NW-1:0]                req_w, fill_w, pop_m;
  logic [CW-1:0]                pop_n;
  logic                         last_step;
  logic                         hit;

  // Unpack the input transfer
  assign in_op   = brfcs_pkg::op_t'(in_tuser);
  assign in_data = in_tdata[7:0];
  assign in_req  = in_tdata[14:8];

  assign load_ok   = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && load_ok;
  assign in_acc    = in_tvalid && in_tready;

  // Pop run length: min(request, fill, longest run)
  always_comb begin
    req_w  = NW'(in_req);
    fill_w = NW'(fill_r);
    pop_m  = (req_w < fill_w) ? req_w : fill_w;
    if (pop_m > NW'(brfcs_pkg::MAX_RUN)) begin
      pop_m = NW'(brfcs_pkg::MAX_RUN);
    end
    pop_n = CW'(pop_m);
  end

  // Search compare at the head cell
  assign last_step = (step_r == SW'(QUEUE_DEPTH - 1));
  assign hit       = !found_r && (FW'(step_r) < fill_r) && (head_byte == char_r);

  // Sequence the operations
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    step_nxt  = step_r;
    found_nxt = found_r;
    dist_nxt  = dist_r;
    char_nxt  = char_r;
    ctl       = '0;
    emit      = 1'b0;
    res_byte  = '0;
    res_flag  = 1'b0;
    res_moved = '0;
    res_last  = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            brfcs_pkg::OP_PUSH: begin
              emit = 1'b1;
              if (fill_r != FW'(QUEUE_DEPTH)) begin
                ctl.push    = 1'b1;
                ctl.byte_in = in_data;
                fill_nxt    = fill_r + FW'(1);
                res_moved   = CW'(1);
              end
            end
            brfcs_pkg::OP_POP: begin
              if (pop_n == '0) begin
                emit = 1'b1;
              end else begin
                state_nxt = S_POP;
                cnt_nxt   = '0;
                total_nxt = pop_n;
              end
            end
            brfcs_pkg::OP_PEEK: begin
              state_nxt = S_PEEK;
              step_nxt  = '0;
              found_nxt = 1'b0;
              dist_nxt  = '0;
              char_nxt  = in_data;
            end
            brfcs_pkg::OP_CLEAR: begin
              fill_nxt = '0;
              emit     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        // Shift out the head byte, one per free output slot
        if (load_ok) begin
          ctl.rotate = 1'b1;
          fill_nxt   = fill_r - FW'(1);
          cnt_nxt    = cnt_r + CW'(1);
          emit       = 1'b1;
          res_byte   = head_byte;
          res_flag   = 1'b1;
          res_moved  = cnt_r + CW'(1);
          res_last   = (cnt_r + CW'(1) == total_r);
          if (res_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PEEK: begin
        // Rotate once round; the final step waits for the output slot
        if (!last_step || load_ok) begin
          ctl.rotate = 1'b1;
          step_nxt   = step_r + SW'(1);
          if (hit) begin
            found_nxt = 1'b1;
            dist_nxt  = FW'(step_r) + FW'(1);
          end
        end
        if (last_step && load_ok) begin
          emit      = 1'b1;
          res_moved = hit ? CW'(FW'(step_r) + FW'(1)) : CW'(dist_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Working registers of pop and peek
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    total_r <= total_nxt;
    step_r  <= step_nxt;
    found_r <= found_nxt;
    dist_r  <= dist_nxt;
    char_r  <= char_nxt;
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (emit) begin
      ob_r     <= res_byte;
      oflag_r  <= res_flag;
      omoved_r <= res_moved;
      olast_r  <= res_last;
      ofill_r  <= CW'(fill_nxt);
      oempty_r <= (fill_nxt == '0);
      ofull_r  <= (fill_nxt == FW'(QUEUE_DEPTH));
    end
  end

  brfcs_chain #(
    .DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .fill      (fill_r),
    .head_byte (head_byte)
  );

  // Drive the result channel
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = oflag_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {ofull_r, oempty_r, ofill_r, omoved_r, ob_r};

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (state_r == S_POP))
    else $error("unmarked result outside a pop run");

  a_pop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (cnt_r < total_r))
    else $error("pop run count overran its length");

  a_pop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && load_ok) |=> (fill_r == $past(fill_r) - FW'(1)))
    else $error("pop step did not drop the fill count");

endmodule
